// ----- hw/rtl/sm3_pkg.sv -----
// Shared types, constants and functions of the SM3 hash engine.
`default_nettype none
package sm3_pkg;

	localparam logic [31:0] T_LOW  = 32'h79CC4519;
	localparam logic [31:0] T_HIGH = 32'h7A879D8A;
	localparam logic [31:0] PAD_WORD = 32'h80000000;
	localparam int unsigned BLOCK_WORDS = 16;
	localparam int unsigned ROUNDS = 64;
	localparam int unsigned LEN_HI_POS = 14;

	localparam logic [31:0] IV [8] = '{
		32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
		32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
	};

	typedef enum logic [1:0] {
		PAD_ZERO = 2'd0,
		PAD_ONE = 2'd1,
		PAD_LEN_HI = 2'd2,
		PAD_LEN_LO = 2'd3
	} pad_sel_t;

	typedef struct packed {
		logic shift_in;
		logic shift_pad;
		pad_sel_t pad_sel;
		logic load_rounds;
		logic round_en;
		logic [5:0] round_idx;
		logic feed;
		logic rearm;
		logic [2:0] out_idx;
	} dp_cmd_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	function automatic logic [31:0] perm0(input logic [31:0] x);
		return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
	endfunction

	function automatic logic [31:0] perm1(input logic [31:0] x);
		return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
	endfunction

	// Valid bytes of a request: anything but a final word carries four.
	function automatic logic [2:0] eff_bytes(input logic [2:0] bv, input logic fin);
		return (!fin || bv > 3'd4) ? 3'd4 : bv;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/sm3_ctrl.sv -----
// Sequencer of the SM3 engine: loading, padding, rounds and digest output.
`default_nettype none
module sm3_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [2:0] bytes_valid,
	input wire logic final_word,
	output logic out_valid,
	input wire logic out_stall,
	output logic [2:0] word_index,
	output logic digest_done,
	output sm3_pkg::dp_cmd_t cmd
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_PAD = 6'b000010,
		S_LOAD = 6'b000100,
		S_ROUND = 6'b001000,
		S_FEED = 6'b010000,
		S_OUT = 6'b100000
	} state_t;

	state_t state_q;
	logic [4:0] cnt_q;
	logic pend_q, padding_q, last_q, lenhi_q;
	logic [5:0] rnd_q;
	logic [2:0] oidx_q;
	logic acc;

	assign in_stall = (state_q != S_IDLE);
	assign acc = in_valid && (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign word_index = oidx_q;
	assign digest_done = (oidx_q == 3'd7);

	always_comb begin
		cmd = '0;
		cmd.shift_in = acc;
		cmd.round_idx = rnd_q;
		cmd.out_idx = oidx_q;
		cmd.load_rounds = (state_q == S_LOAD);
		cmd.round_en = (state_q == S_ROUND);
		cmd.feed = (state_q == S_FEED);
		cmd.rearm = (state_q == S_OUT) && !out_stall && (oidx_q == 3'd7);
		if (state_q == S_PAD && cnt_q != 5'(sm3_pkg::BLOCK_WORDS)) begin
			cmd.shift_pad = 1'b1;
			if (pend_q)
				cmd.pad_sel = sm3_pkg::PAD_ONE;
			else if (cnt_q == 5'(sm3_pkg::LEN_HI_POS))
				cmd.pad_sel = sm3_pkg::PAD_LEN_HI;
			else if (lenhi_q && cnt_q == 5'(sm3_pkg::LEN_HI_POS + 1))
				cmd.pad_sel = sm3_pkg::PAD_LEN_LO;
			else
				cmd.pad_sel = sm3_pkg::PAD_ZERO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			pend_q <= 1'b0;
			padding_q <= 1'b0;
			last_q <= 1'b0;
			lenhi_q <= 1'b0;
			rnd_q <= '0;
			oidx_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						cnt_q <= cnt_q + 5'd1;
						if (final_word) begin
							padding_q <= 1'b1;
							pend_q <= (sm3_pkg::eff_bytes(bytes_valid, final_word) == 3'd4);
							state_q <= (cnt_q == 5'(sm3_pkg::BLOCK_WORDS - 1)) ? S_LOAD : S_PAD;
						end else if (cnt_q == 5'(sm3_pkg::BLOCK_WORDS - 1)) begin
							state_q <= S_LOAD;
						end
					end
				end
				S_PAD: begin
					if (cnt_q == 5'(sm3_pkg::BLOCK_WORDS)) begin
						state_q <= S_LOAD;
					end else begin
						cnt_q <= cnt_q + 5'd1;
						pend_q <= 1'b0;
						if (cmd.pad_sel == sm3_pkg::PAD_LEN_HI) lenhi_q <= 1'b1;
						if (cmd.pad_sel == sm3_pkg::PAD_LEN_LO) last_q <= 1'b1;
					end
				end
				S_LOAD: begin
					rnd_q <= '0;
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'(sm3_pkg::ROUNDS - 1)) state_q <= S_FEED;
				end
				S_FEED: begin
					cnt_q <= '0;
					lenhi_q <= 1'b0;
					oidx_q <= '0;
					if (last_q) state_q <= S_OUT;
					else if (padding_q) state_q <= S_PAD;
					else state_q <= S_IDLE;
				end
				S_OUT: begin
					if (!out_stall) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							padding_q <= 1'b0;
							last_q <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/sm3_dp.sv -----
// SM3 datapath: message window, round registers, chaining value and length.
`default_nettype none
module sm3_dp (
	input wire logic clk,
	input wire logic arst_n,
	input wire sm3_pkg::dp_cmd_t cmd,
	input wire logic [31:0] message_word,
	input wire logic [2:0] bytes_valid,
	input wire logic final_word,
	output logic [31:0] digest_word
);

	logic [31:0] w_q [16];
	logic [31:0] r_q [8];
	logic [31:0] cv_q [8];
	logic [63:0] len_q;
	logic [2:0] eb;
	logic [31:0] fmt_word, pad_word, exp_word, new_word;
	logic [31:0] t, a12, ss1, ss2, ff, gg, tt1, tt2;
	logic low;

	assign eb = sm3_pkg::eff_bytes(bytes_valid, final_word);

	always_comb begin
		case (eb)
			3'd0: fmt_word = sm3_pkg::PAD_WORD;
			3'd1: fmt_word = {message_word[31:24], 24'h800000};
			3'd2: fmt_word = {message_word[31:16], 16'h8000};
			3'd3: fmt_word = {message_word[31:8], 8'h80};
			default: fmt_word = message_word;
		endcase
		case (cmd.pad_sel)
			sm3_pkg::PAD_ONE: pad_word = sm3_pkg::PAD_WORD;
			sm3_pkg::PAD_LEN_HI: pad_word = len_q[63:32];
			sm3_pkg::PAD_LEN_LO: pad_word = len_q[31:0];
			default: pad_word = '0;
		endcase
	end

	// The window holds W[j] .. W[j+15] at round j.
	assign exp_word = sm3_pkg::perm1(w_q[0] ^ w_q[7] ^ sm3_pkg::rotl(w_q[13], 5'd15))
		^ sm3_pkg::rotl(w_q[3], 5'd7) ^ w_q[10];
	assign new_word = cmd.shift_in ? fmt_word : (cmd.shift_pad ? pad_word : exp_word);

	assign low = (cmd.round_idx < 6'd16);
	assign t = low ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
	assign a12 = sm3_pkg::rotl(r_q[0], 5'd12);
	assign ss1 = sm3_pkg::rotl(a12 + r_q[4] + sm3_pkg::rotl(t, cmd.round_idx[4:0]), 5'd7);
	assign ss2 = ss1 ^ a12;
	assign ff = low ? (r_q[0] ^ r_q[1] ^ r_q[2])
		: ((r_q[0] & r_q[1]) | (r_q[0] & r_q[2]) | (r_q[1] & r_q[2]));
	assign gg = low ? (r_q[4] ^ r_q[5] ^ r_q[6]) : ((r_q[4] & r_q[5]) | (~r_q[4] & r_q[6]));
	assign tt1 = ff + r_q[3] + ss2 + (w_q[0] ^ w_q[4]);
	assign tt2 = gg + r_q[7] + ss1 + w_q[0];

	assign digest_word = cv_q[cmd.out_idx];

	always_ff @(posedge clk) begin
		if (cmd.shift_in || cmd.shift_pad || cmd.round_en) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
			w_q[15] <= new_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				r_q[i] <= '0;
				cv_q[i] <= sm3_pkg::IV[i];
			end
			len_q <= '0;
		end else begin
			if (cmd.shift_in) len_q <= len_q + {58'd0, eb, 3'd0};
			if (cmd.load_rounds) begin
				for (int i = 0; i < 8; i++) r_q[i] <= cv_q[i];
			end else if (cmd.round_en) begin
				r_q[3] <= r_q[2];
				r_q[2] <= sm3_pkg::rotl(r_q[1], 5'd9);
				r_q[1] <= r_q[0];
				r_q[0] <= tt1;
				r_q[7] <= r_q[6];
				r_q[6] <= sm3_pkg::rotl(r_q[5], 5'd19);
				r_q[5] <= r_q[4];
				r_q[4] <= sm3_pkg::perm0(tt2);
			end
			if (cmd.feed) begin
				for (int i = 0; i < 8; i++) cv_q[i] <= cv_q[i] ^ r_q[i];
			end else if (cmd.rearm) begin
				for (int i = 0; i < 8; i++) cv_q[i] <= sm3_pkg::IV[i];
				len_q <= '0;
			end
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/sm3_hash_engine.sv -----
// Top level of the SM3 hash engine.
//
// Channel   Direction  Handshake            Payload
// input     in         in_valid/in_stall    message_word, bytes_valid, final_word
// output    out        out_valid/out_stall  digest_word, word_index, digest_done
//
// One word is taken per cycle until 16 words fill a block; a block then passes
// through the round unit in load, 64 rounds and chaining feedback.
// The final request adds the padding words, up to one extra block, and the
// eight digest words. No request is taken while a block or the digest is busy.
// Reset loads the IV and clears the length and all control state.
`default_nettype none
module sm3_hash_engine (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [31:0] message_word,
	input wire logic [2:0] bytes_valid,
	input wire logic final_word,
	output logic out_valid,
	input wire logic out_stall,
	output logic [31:0] digest_word,
	output logic [2:0] word_index,
	output logic digest_done
);

	sm3_pkg::dp_cmd_t cmd;

	sm3_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.bytes_valid(bytes_valid),
		.final_word(final_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.word_index(word_index),
		.digest_done(digest_done),
		.cmd(cmd)
	);

	sm3_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.message_word(message_word),
		.bytes_valid(bytes_valid),
		.final_word(final_word),
		.digest_word(digest_word)
	);

endmodule
`default_nettype wire
